FILE: rtl/lce_pkg.sv
package lce_pkg;

  localparam int KEY_W  = 64;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 5;
  localparam int IN_W   = 192;
  localparam int OUT_W  = 72;
  localparam int CFG_W  = 5;

  typedef enum logic [1:0] {
    OP_INS_POS = 2'd0,
    OP_INS_NEG = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_TRIM    = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_REMOVE,
    CMD_PROMOTE,
    CMD_PUSH,
    CMD_DROP
  } cmd_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ACT,
    S_PUSH,
    S_DROP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [31:0]      handle;
    logic [31:0]      flags;
    logic [31:0]      expiry;
    logic             negative;
  } entry_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last;
  } cell_cmd_t;

endpackage

FILE: rtl/lru_cache_with_expiry_top.sv
// lru cache with per-entry expiry, entries kept in a row of cells ordered
// by recency (cell 0 most recent, valid cells packed from cell 0 upward).
// input channel in_*: one transaction is one operation, opcode on in_tuser,
// key, handle, flags, lifespan and current time on in_tdata.
// output channel out_*: exactly one result transaction per operation.
// config port cfg_*: cfg_we writes register cfg_addr (0 enable, 1 slot
// limit) at the clock edge; write only while no operation is in flight.
// the row moves through its steps in order (match capture, remove/promote,
// push, drop) under one sequencer; a trim repeats the drop step for each
// evicted entry.
// throughput: one operation at a time, a new one is taken once the
// result has moved to the output register.
// reset (rst_n low, synchronous) empties the cache, enables it and sets
// the limit to the full capacity.
// when the receiver stalls the result holds in the output register and
// the next operation may still be accepted and worked on; it waits in its
// final step until the output register frees.
module lru_cache_with_expiry_top #(
  parameter int CAPACITY = 16,
  parameter int ANY_CODE = 255
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // name_key, query_class, query_type, data_handle, entry_flags, lifespan, now
  input  logic [lce_pkg::IN_W-1:0]     in_tdata,
  // opcode
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // hit, negative_hit, out_handle, out_flags, entry_count, ignored
  output logic [lce_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [lce_pkg::CFG_W-1:0]    cfg_wdata
);
  import lce_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int LW = (OW > CFG_W) ? OW : CFG_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
  localparam logic [15:0]  ANY_C = 16'(ANY_CODE);

  state_t state_r, state_nxt;

  logic          enable_r;
  logic [CFG_W-1:0] limit_r;
  opcode_t       op_r;
  logic [KEY_W-1:0] key_r;
  logic [31:0]   handle_r, flags_r, expiry_r, now_r;
  logic          match_any_r;
  logic [PW-1:0] pos_r;
  logic [OW-1:0] occ_r, occ_nxt;
  logic          hit_r, neg_r, ign_r;
  logic [31:0]   oh_r, of_r;
  logic          set_hit, set_ign;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  cell_cmd_t     cmd;
  entry_t        ents [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  entry_t        new_ent, sel_ent, empty_ent;

  logic [32:0]   exp_sum;
  logic          match_any;
  logic [PW-1:0] match_pos;
  logic [LW-1:0] lim, occ_l;
  logic          over_lim, is_any, live;

  assign exp_sum = {1'b0, in_tdata[191:160]} + {1'b0, in_tdata[159:128]};
  assign is_any  = (key_r[31:16] == ANY_C) || (key_r[15:0] == ANY_C);

  always_comb begin
    if (limit_r == '0 || LW'(limit_r) > CAP_L) lim = CAP_L;
    else lim = LW'(limit_r);
  end
  assign occ_l    = LW'(occ_r);
  assign over_lim = occ_l > lim;

  always_comb begin
    match_any = 1'b0;
    match_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_any = 1'b1;
        match_pos = PW'(i);
      end
    end
  end

  assign sel_ent = ents[pos_r];
  assign live    = now_r < sel_ent.expiry;

  always_comb begin
    new_ent.valid    = 1'b1;
    new_ent.key      = key_r;
    new_ent.handle   = (op_r == OP_INS_NEG) ? 32'd0 : handle_r;
    new_ent.flags    = flags_r;
    new_ent.expiry   = expiry_r;
    new_ent.negative = (op_r == OP_INS_NEG);
  end
  assign empty_ent = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lce_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .prev_entry((g == 0) ? empty_ent : ents[(g == 0) ? 0 : g - 1]),
      .next_entry((g == CAPACITY - 1) ? empty_ent : ents[(g == CAPACITY - 1) ? g : g + 1]),
      .new_entry (new_ent),
      .sel_entry (sel_ent),
      .probe_key (key_r),
      .entry     (ents[g]),
      .match     (match_vec[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_ACT;
      S_ACT: begin
        if (!enable_r || op_r == OP_LOOKUP || (op_r == OP_INS_NEG && is_any))
          state_nxt = S_DONE;
        else if (op_r == OP_TRIM) state_nxt = S_DROP;
        else state_nxt = S_PUSH;
      end
      S_PUSH: state_nxt = S_DROP;
      S_DROP: begin
        if (!(op_r == OP_TRIM && over_lim)) state_nxt = S_DONE;
      end
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell commands and result flags
  always_comb begin
    cmd.kind = CMD_HOLD;
    cmd.pos  = POS_W'(pos_r);
    cmd.last = POS_W'(occ_r - OW'(1));
    occ_nxt  = occ_r;
    set_hit  = 1'b0;
    set_ign  = 1'b0;
    case (state_r)
      S_ACT: begin
        if (!enable_r) begin
          set_ign = 1'b1;
        end else if (op_r == OP_INS_NEG && is_any) begin
          set_ign = 1'b1;
        end else if (op_r != OP_TRIM && match_any_r) begin
          if (op_r == OP_LOOKUP && live) begin
            cmd.kind = CMD_PROMOTE;
            set_hit  = 1'b1;
          end else begin
            cmd.kind = CMD_REMOVE;
            occ_nxt  = occ_r - OW'(1);
          end
        end
      end
      S_PUSH: begin
        cmd.kind = CMD_PUSH;
        if (occ_l < CAP_L) occ_nxt = occ_r + OW'(1);
      end
      S_DROP: begin
        if (over_lim) begin
          cmd.kind = CMD_DROP;
          occ_nxt  = occ_r - OW'(1);
        end
      end
      default: cmd.kind = CMD_HOLD;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      enable_r    <= 1'b1;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (cfg_we) begin
        if (cfg_addr == REG_ENABLE) enable_r <= cfg_wdata[0];
        else limit_r <= cfg_wdata;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= opcode_t'(in_tuser);
      key_r    <= {in_tdata[31:0], in_tdata[47:32], in_tdata[63:48]};
      handle_r <= in_tdata[95:64];
      flags_r  <= in_tdata[127:96];
      expiry_r <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
      now_r    <= in_tdata[191:160];
      hit_r    <= 1'b0;
      neg_r    <= 1'b0;
      oh_r     <= '0;
      of_r     <= '0;
      ign_r    <= 1'b0;
    end
    if (state_r == S_LOOK) begin
      match_any_r <= match_any;
      pos_r       <= match_pos;
    end
    if (set_hit) begin
      hit_r <= 1'b1;
      neg_r <= sel_ent.negative;
      oh_r  <= sel_ent.handle;
      of_r  <= sel_ent.flags;
    end
    if (set_ign) ign_r <= 1'b1;
    if (state_r == S_DONE && (!out_valid_r || out_tready))
      out_data_r <= {ign_r, CNT_W'(occ_r), of_r, oh_r, neg_r, hit_r};
  end

endmodule

FILE: rtl/lce_cell.sv
module lce_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lce_pkg::cell_cmd_t    cmd,
  input  lce_pkg::entry_t       prev_entry,
  input  lce_pkg::entry_t       next_entry,
  input  lce_pkg::entry_t       new_entry,
  input  lce_pkg::entry_t       sel_entry,
  input  logic [lce_pkg::KEY_W-1:0] probe_key,
  output lce_pkg::entry_t       entry,
  output logic                  match
);
  import lce_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  entry_t ent_r, ent_nxt;

  assign entry = ent_r;
  assign match = ent_r.valid && (ent_r.key == probe_key);

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.kind)
      CMD_REMOVE: begin
        if (MY_IDX >= cmd.pos) ent_nxt = next_entry;
      end
      CMD_PROMOTE: begin
        if (MY_IDX == '0) ent_nxt = sel_entry;
        else if (MY_IDX <= cmd.pos) ent_nxt = prev_entry;
      end
      CMD_PUSH: begin
        if (MY_IDX == '0) ent_nxt = new_entry;
        else ent_nxt = prev_entry;
      end
      CMD_DROP: begin
        if (MY_IDX == cmd.last) ent_nxt.valid = 1'b0;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r.valid <= 1'b0;
    else ent_r <= ent_nxt;
  end

endmodule
